[src/ntp_pkg.sv]
// Shared constants and types of the NTT twiddle preconditioner and packer.
package ntp_pkg;

    localparam int WORD_W      = 64;
    localparam int SHIFT_W     = 7;
    localparam int LOG_W       = 5;
    localparam int LANES       = 8;
    localparam int STAGE_OUT_W = 4;
    localparam int VEC_OUT_W   = 12;
    localparam int COUNT_W     = 8;
    localparam int MIN_LOG     = 4;
    localparam logic [SHIFT_W-1:0] MAX_SHIFT = 7'd64;

    // Packed-layout position of one twiddle.
    typedef struct packed {
        logic [STAGE_OUT_W-1:0] stage;
        logic [VEC_OUT_W-1:0]   vector_index;
        logic [LANES-1:0]       lane_mask;
        logic                   last;
    } ntp_layout_t;

endpackage

[src/ntt_twiddle_precon_packer.sv]
// Top level of the NTT twiddle preconditioner and packer.
//
// Twiddles of an NTT schedule enter one per request on the input channel
// (in_valid, in_ready, twiddle_in), in schedule order starting at schedule
// index 0. For each one the output channel (out_valid, out_ready) returns the
// twiddle, its preconditioner floor((w << shift) / q) truncated to 64 bits,
// and its stage, vector index and lane mask in the 8-lane packed layout.
// last_of_schedule marks the final twiddle, after which the position wraps.
//
// The bit-serial divider retires one dividend bit per cycle, first the twiddle
// bits and then one zero bit per shift position. in_ready is high only while
// no request is in the divider or waiting for the output register, so a new
// request is taken only after the last one has moved to the output register.
//
// A finished result waits in the output register while out_ready is low; the
// next result stays in the divider until the register is free, and no new
// request is accepted meanwhile. Reset clears the schedule position and loads
// the register defaults (modulus 2, shift 64, log size 12, forward order).
// Registers sit on an APB port at byte addresses 0, 8, 16 and 24.
module ntt_twiddle_precon_packer #(
    parameter int MAX_LOG_SIZE = 16
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // Input channel.
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [ntp_pkg::WORD_W-1:0]            twiddle_in,
    // Output channel.
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [ntp_pkg::STAGE_OUT_W-1:0]       stage,
    output logic [ntp_pkg::VEC_OUT_W-1:0]         vector_index,
    output logic [ntp_pkg::LANES-1:0]             lane_mask,
    output logic [ntp_pkg::WORD_W-1:0]            twiddle_out,
    output logic [ntp_pkg::WORD_W-1:0]            precon,
    output logic                                  last_of_schedule,
    // Configuration port.
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [4:0]                            paddr,
    input  logic [ntp_pkg::WORD_W-1:0]            pwdata,
    output logic [ntp_pkg::WORD_W-1:0]            prdata,
    output logic                                  pready
);

    typedef enum logic [1:0] {
        REG_MODULUS,
        REG_SHIFT,
        REG_LOG_SIZE,
        REG_INVERSE
    } reg_index_t;

    typedef enum logic {
        ST_IDLE,
        ST_DIVIDE
    } state_t;

    state_t                             state_reg;
    logic [ntp_pkg::WORD_W-1:0]         modulus_reg;
    logic [ntp_pkg::SHIFT_W-1:0]        shift_reg;
    logic [ntp_pkg::LOG_W-1:0]          log_size_reg;
    logic                               inverse_reg;
    ntp_pkg::ntp_layout_t               pend_layout_reg;
    logic [ntp_pkg::WORD_W-1:0]         pend_twiddle_reg;
    logic                               out_valid_reg;
    ntp_pkg::ntp_layout_t               out_layout_reg;
    logic [ntp_pkg::WORD_W-1:0]         out_twiddle_reg;
    logic [ntp_pkg::WORD_W-1:0]         out_precon_reg;

    logic                               in_accept;
    logic                               out_free;
    logic                               out_load;
    logic                               cfg_write;
    reg_index_t                         reg_index;
    logic [ntp_pkg::SHIFT_W-1:0]        shift_eff;
    ntp_pkg::ntp_layout_t               layout;
    logic                               div_busy;
    logic [ntp_pkg::WORD_W-1:0]         div_quotient;

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_accept = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign reg_index = reg_index_t'(paddr[4:3]);

    // The finished result moves out once the divider is done and the
    // output register is free.
    assign out_load  = (state_reg == ST_DIVIDE) && !div_busy && out_free;

    // Shifts above one word behave as a full-word shift.
    assign shift_eff = (shift_reg > ntp_pkg::MAX_SHIFT) ? ntp_pkg::MAX_SHIFT : shift_reg;

    always_comb
    begin
        unique case (reg_index)
            REG_MODULUS:  prdata = modulus_reg;
            REG_SHIFT:    prdata = ntp_pkg::WORD_W'(shift_reg);
            REG_LOG_SIZE: prdata = ntp_pkg::WORD_W'(log_size_reg);
            REG_INVERSE:  prdata = ntp_pkg::WORD_W'(inverse_reg);
            default:      prdata = '0;
        endcase
    end

    // The position steps forward as each request is taken, so the layout
    // of the request is captured alongside its twiddle.
    ntp_position #(
        .MAX_LOG_SIZE(MAX_LOG_SIZE)
    ) u_position (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (in_accept),
        .log_size       (log_size_reg),
        .inverse_layout (inverse_reg),
        .layout         (layout)
    );

    ntp_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (in_accept),
        .twiddle  (twiddle_in),
        .shift    (shift_eff),
        .divisor  (modulus_reg),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            modulus_reg   <= ntp_pkg::WORD_W'(2);
            shift_reg     <= ntp_pkg::SHIFT_W'(64);
            log_size_reg  <= ntp_pkg::LOG_W'(12);
            inverse_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (reg_index)
                    REG_MODULUS:  modulus_reg  <= pwdata;
                    REG_SHIFT:    shift_reg    <= pwdata[ntp_pkg::SHIFT_W-1:0];
                    REG_LOG_SIZE: log_size_reg <= pwdata[ntp_pkg::LOG_W-1:0];
                    REG_INVERSE:  inverse_reg  <= pwdata[0];
                    default:      ;
                endcase
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        pend_layout_reg  <= layout;
                        pend_twiddle_reg <= twiddle_in;
                        state_reg        <= ST_DIVIDE;
                    end
                end
                ST_DIVIDE:
                begin
                    // Move the finished result out once the register is free.
                    if (out_load)
                    begin
                        out_layout_reg  <= pend_layout_reg;
                        out_twiddle_reg <= pend_twiddle_reg;
                        out_precon_reg  <= div_quotient;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign out_valid        = out_valid_reg;
    assign stage            = out_layout_reg.stage;
    assign vector_index     = out_layout_reg.vector_index;
    assign lane_mask        = out_layout_reg.lane_mask;
    assign last_of_schedule = out_layout_reg.last;
    assign twiddle_out      = out_twiddle_reg;
    assign precon           = out_precon_reg;

endmodule

[src/ntp_divider.sv]
// Bit-serial restoring divider for the shifted-twiddle preconditioner.
module ntp_divider (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [ntp_pkg::WORD_W-1:0]        twiddle,
    input  logic [ntp_pkg::SHIFT_W-1:0]       shift,
    input  logic [ntp_pkg::WORD_W-1:0]        divisor,
    output logic                              busy,
    output logic [ntp_pkg::WORD_W-1:0]        quotient
);

    logic                              busy_reg;
    logic [ntp_pkg::COUNT_W-1:0]       count_reg;
    logic [ntp_pkg::WORD_W-1:0]        rem_reg;
    logic [ntp_pkg::WORD_W-1:0]        quo_reg;
    logic [ntp_pkg::WORD_W-1:0]        data_reg;
    logic                              carry;
    logic [ntp_pkg::WORD_W-1:0]        rem_shift;
    logic                              take;
    logic [ntp_pkg::WORD_W-1:0]        rem_next;

    // One restoring step; a carry out of the remainder forces a subtract.
    always_comb
    begin
        carry     = rem_reg[ntp_pkg::WORD_W-1];
        rem_shift = {rem_reg[ntp_pkg::WORD_W-2:0], data_reg[ntp_pkg::WORD_W-1]};
        take      = carry || (rem_shift >= divisor);
        rem_next  = take ? (rem_shift - divisor) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
        end
        else if (start)
        begin
            busy_reg  <= 1'b1;
            // The twiddle bits come first, then one zero bit per shift position.
            count_reg <= ntp_pkg::COUNT_W'(ntp_pkg::WORD_W) + ntp_pkg::COUNT_W'(shift);
            rem_reg   <= '0;
            quo_reg   <= '0;
            data_reg  <= twiddle;
        end
        else if (busy_reg)
        begin
            rem_reg   <= rem_next;
            quo_reg   <= {quo_reg[ntp_pkg::WORD_W-2:0], take};
            data_reg  <= {data_reg[ntp_pkg::WORD_W-2:0], 1'b0};
            count_reg <= count_reg - ntp_pkg::COUNT_W'(1);
            if (count_reg == ntp_pkg::COUNT_W'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

[src/ntp_position.sv]
// Schedule position tracker and 8-lane packed layout decoder.
module ntp_position #(
    parameter int MAX_LOG_SIZE = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          advance,
    input  logic [ntp_pkg::LOG_W-1:0]     log_size,
    input  logic                          inverse_layout,
    output ntp_pkg::ntp_layout_t          layout
);

    localparam int SW  = $clog2(MAX_LOG_SIZE);
    localparam int LW  = $clog2(MAX_LOG_SIZE + 1);
    localparam int IW  = MAX_LOG_SIZE - 1;
    localparam int SZW = MAX_LOG_SIZE;

    typedef enum logic [1:0] {
        SHAPE_BCAST,
        SHAPE_PAIR,
        SHAPE_QUAD,
        SHAPE_OCT
    } shape_t;

    logic [SW-1:0]  stage_counter_reg, stage_counter_next;
    logic [IW-1:0]  index_in_stage_reg, index_in_stage_next;

    logic [5:0]     log_wide;
    logic [LW-1:0]  log_eff;
    logic [SW-1:0]  s;
    logic [IW-1:0]  i;
    logic [SZW-1:0] size;
    logic [SZW-1:0] i_plus;
    shape_t         shape;
    logic [IW-1:0]  vec;
    logic [ntp_pkg::LANES-1:0] mask;

    function automatic logic [SZW-1:0] stage_size(input logic [LW-1:0] l,
                                                  input logic [SW-1:0] st,
                                                  input logic inv);
        logic [SZW-1:0] sz;
        if (inv)
        begin
            sz = SZW'(1) << (l - LW'(st) - LW'(1));
        end
        else
        begin
            sz = SZW'(1) << st;
        end
        return sz;
    endfunction

    function automatic shape_t stage_shape(input logic [LW-1:0] l,
                                           input logic [SW-1:0] st,
                                           input logic inv);
        shape_t         sh;
        logic [LW:0]    sw;
        logic [LW:0]    lw;
        sw = (LW+1)'(st);
        lw = (LW+1)'(l);
        sh = SHAPE_BCAST;
        if (inv)
        begin
            if (st == SW'(0))
                sh = SHAPE_OCT;
            else if (st == SW'(1))
                sh = SHAPE_QUAD;
            else if (st == SW'(2))
                sh = SHAPE_PAIR;
        end
        else
        begin
            if (sw + (LW+1)'(1) == lw)
                sh = SHAPE_OCT;
            else if (sw + (LW+1)'(2) == lw)
                sh = SHAPE_QUAD;
            else if (sw + (LW+1)'(3) == lw)
                sh = SHAPE_PAIR;
        end
        return sh;
    endfunction

    always_comb
    begin
        // Clamp the transform length into the supported range.
        log_wide = {1'b0, log_size};
        if (log_wide < 6'(ntp_pkg::MIN_LOG))
            log_wide = 6'(ntp_pkg::MIN_LOG);
        if (log_wide > 6'(MAX_LOG_SIZE))
            log_wide = 6'(MAX_LOG_SIZE);
        log_eff = LW'(log_wide);

        // A stored position outside the current schedule restarts it.
        s = stage_counter_reg;
        i = index_in_stage_reg;
        if (LW'(s) >= log_eff)
        begin
            s = '0;
            i = '0;
        end
        size = stage_size(log_eff, s, inverse_layout);
        if (SZW'(i) >= size)
        begin
            s    = '0;
            i    = '0;
            size = stage_size(log_eff, s, inverse_layout);
        end
        shape = stage_shape(log_eff, s, inverse_layout);

        case (shape)
            SHAPE_OCT:
            begin
                vec  = i >> 3;
                mask = ntp_pkg::LANES'(1) << i[2:0];
            end
            SHAPE_QUAD:
            begin
                vec  = i >> 2;
                mask = ntp_pkg::LANES'(2'b11) << {i[1:0], 1'b0};
            end
            SHAPE_PAIR:
            begin
                vec  = i >> 1;
                mask = ntp_pkg::LANES'(4'hF) << {i[0], 2'b00};
            end
            default:
            begin
                vec  = i;
                mask = '1;
            end
        endcase

        i_plus = SZW'(i) + SZW'(1);

        layout.stage        = ntp_pkg::STAGE_OUT_W'(s);
        layout.vector_index = ntp_pkg::VEC_OUT_W'(vec);
        layout.lane_mask    = mask;
        layout.last         = (LW'(s) + LW'(1) == log_eff) && (i_plus == size);

        if (i_plus >= size)
        begin
            index_in_stage_next = '0;
            stage_counter_next  = (LW'(s) + LW'(1) >= log_eff) ? '0 : s + SW'(1);
        end
        else
        begin
            index_in_stage_next = i + IW'(1);
            stage_counter_next  = s;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_counter_reg  <= '0;
            index_in_stage_reg <= '0;
        end
        else if (advance)
        begin
            stage_counter_reg  <= stage_counter_next;
            index_in_stage_reg <= index_in_stage_next;
        end
    end

endmodule
